// ----- src/gbhs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbhs_pkg
// Shared types and constants of the bilinear height sampler: default
// dimensions, fixed port widths, item kinds and configuration register codes.
// ----------------------------------------------------------------------------
package gbhs_pkg;

	localparam int GRID_COLS_DEF = 256;
	localparam int GRID_ROWS_DEF = 256;
	localparam int FRAC_BITS_DEF = 8;
	localparam int COST_BITS_DEF = 8;

	localparam int CELL_W     = 8;
	localparam int POS_W      = 16;
	localparam int OFFSET_W   = 16;
	localparam int HEIGHT_W   = 26;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// offset register is in units of 1/256
	localparam int OFFSET_FRAC = 8;

	typedef enum logic {
		KIND_WRITE  = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAP_PRESENT   = 1'b0,
		CFG_HEIGHT_OFFSET = 1'b1
	} cfg_reg_t;

endpackage

// ----- src/gbhs_bank.sv -----
// ----------------------------------------------------------------------------
// gbhs_bank
// One bank of the cost grid: a synchronous RAM with one write port and one
// read port, read data registered.
// ----------------------------------------------------------------------------
module gbhs_bank #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/grid_bilinear_height_sampler.sv -----
// ----------------------------------------------------------------------------
// grid_bilinear_height_sampler
// Cost grid loaded by write items; sample items blend the four cells around
// an 8.8 position bilinearly and add a configured height offset.
// A sample passes the valid_s1, valid_s2 and valid_s3 registers before done
// rises, together with the registered height and edge_clamped.
// Throughput: one item (write or sample) per clock; busy is high only while
// reset is asserted, since the grid is split into four banks by row and
// column parity, so the four corners are read in the same cycle. Results
// cannot be stalled.
// Reset clears configuration and pipeline valids; grid contents are kept.
// ----------------------------------------------------------------------------
module grid_bilinear_height_sampler #(
	parameter int GRID_COLS = gbhs_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gbhs_pkg::GRID_ROWS_DEF,
	parameter int FRAC_BITS = gbhs_pkg::FRAC_BITS_DEF,
	parameter int COST_BITS = gbhs_pkg::COST_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic [gbhs_pkg::CELL_W-1:0]          cell_col,
	input  logic [gbhs_pkg::CELL_W-1:0]          cell_row,
	input  logic [gbhs_pkg::CELL_W-1:0]          cell_cost,
	input  logic [gbhs_pkg::POS_W-1:0]           pos_x,
	input  logic [gbhs_pkg::POS_W-1:0]           pos_y,
	output logic                                 done,
	output logic signed [gbhs_pkg::HEIGHT_W-1:0] height,
	output logic                                 edge_clamped,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gbhs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gbhs_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CW     = $clog2(GRID_COLS);
	localparam int RW     = $clog2(GRID_ROWS);
	localparam int IW     = gbhs_pkg::POS_W + 1;
	localparam int BCOLS  = (GRID_COLS + 1) / 2;
	localparam int BROWS  = (GRID_ROWS + 1) / 2;
	localparam int BDEPTH = BCOLS * BROWS;
	localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
	localparam int VW     = (COST_BITS < 2) ? 2 : COST_BITS;
	localparam int WW     = FRAC_BITS + 1;
	localparam int LW     = FRAC_BITS + VW;
	localparam int SW     = 2 * FRAC_BITS + VW;
	localparam int HW     = gbhs_pkg::HEIGHT_W;
	localparam int OSH    = 2 * FRAC_BITS + 1 - gbhs_pkg::OFFSET_FRAC;
	localparam int OSH_L  = (OSH > 0) ? OSH : 0;
	localparam int OSH_R  = (OSH < 0) ? -OSH : 0;
	localparam int EW0    = (SW + 1 > gbhs_pkg::OFFSET_W + OSH_L) ?
		SW + 1 : gbhs_pkg::OFFSET_W + OSH_L;
	localparam int EW     = ((EW0 > HW) ? EW0 : HW) + 1;

	localparam logic [IW-1:0] LAST_C = IW'(GRID_COLS - 1);
	localparam logic [IW-1:0] LAST_R = IW'(GRID_ROWS - 1);
	localparam logic [WW-1:0] ONE    = WW'(1) << FRAC_BITS;
	localparam logic signed [EW-1:0] H_MAX =
		{{(EW - HW + 1){1'b0}}, {(HW - 1){1'b1}}};
	localparam logic signed [EW-1:0] H_MIN =
		{{(EW - HW + 1){1'b1}}, {(HW - 1){1'b0}}};

	// configuration
	logic                                 map_present_q;
	logic signed [gbhs_pkg::OFFSET_W-1:0] offset_q;

	// no transfer on either channel while reset is asserted
	assign cfg_ready = arst_n;
	assign busy      = !arst_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_present_q <= 1'b0;
			offset_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (gbhs_pkg::cfg_reg_t'(cfg_index))
				gbhs_pkg::CFG_MAP_PRESENT:   map_present_q <= cfg_data[0];
				gbhs_pkg::CFG_HEIGHT_OFFSET: offset_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// stage 0: decode, corner indices, bank addresses
	logic                 accept;
	logic                 do_write;
	logic                 do_sample;
	logic                 wr_in_grid;
	logic [CW-1:0]        wr_c;
	logic [RW-1:0]        wr_r;
	logic [BAW-1:0]       waddr;
	logic [COST_BITS-1:0] wdata;
	logic [FRAC_BITS-1:0] fx;
	logic [FRAC_BITS-1:0] fy;
	logic [IW-1:0]        ix0;
	logic [IW-1:0]        ix1;
	logic [IW-1:0]        iy0;
	logic [IW-1:0]        iy1;
	logic [CW-1:0]        c0;
	logic [CW-1:0]        c1;
	logic [RW-1:0]        r0;
	logic [RW-1:0]        r1;
	logic                 clamp;

	assign accept    = start && !busy;
	assign do_write  = accept && (gbhs_pkg::kind_t'(kind) == gbhs_pkg::KIND_WRITE);
	assign do_sample = accept && (gbhs_pkg::kind_t'(kind) == gbhs_pkg::KIND_SAMPLE);

	always_comb begin
		wr_in_grid = (32'(cell_col) < 32'(GRID_COLS)) && (32'(cell_row) < 32'(GRID_ROWS));
		wr_c       = CW'(cell_col);
		wr_r       = RW'(cell_row);
		waddr      = BAW'(wr_r >> 1) * BAW'(BCOLS) + BAW'(wr_c >> 1);
		wdata      = COST_BITS'(cell_cost);

		fx  = pos_x[FRAC_BITS-1:0];
		fy  = pos_y[FRAC_BITS-1:0];
		ix0 = {1'b0, pos_x} >> FRAC_BITS;
		iy0 = {1'b0, pos_y} >> FRAC_BITS;
		ix1 = ix0 + IW'(fx != '0);
		iy1 = iy0 + IW'(fy != '0);

		// corners past the last row or column saturate to the edge
		clamp = 1'b0;
		c0 = CW'(ix0);
		c1 = CW'(ix1);
		r0 = RW'(iy0);
		r1 = RW'(iy1);
		if (ix0 > LAST_C) begin
			c0 = CW'(LAST_C);
			clamp = 1'b1;
		end
		if (ix1 > LAST_C) begin
			c1 = CW'(LAST_C);
			clamp = 1'b1;
		end
		if (iy0 > LAST_R) begin
			r0 = RW'(LAST_R);
			clamp = 1'b1;
		end
		if (iy1 > LAST_R) begin
			r1 = RW'(LAST_R);
			clamp = 1'b1;
		end
	end

	// four banks by (row parity, column parity), bank index {row bit, col bit}
	logic [COST_BITS-1:0] bank_rd_s1 [4];

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic          rb;
		logic          cb;
		logic [RW-1:0] rsel;
		logic [CW-1:0] csel;
		logic [BAW-1:0] raddr;
		logic          we;

		assign rb    = 1'(b >> 1);
		assign cb    = 1'(b & 1);
		assign rsel  = (r0[0] == rb) ? r0 : r1;
		assign csel  = (c0[0] == cb) ? c0 : c1;
		assign raddr = BAW'(rsel >> 1) * BAW'(BCOLS) + BAW'(csel >> 1);
		assign we    = do_write && wr_in_grid && (wr_r[0] == rb) && (wr_c[0] == cb);

		gbhs_bank #(
			.DEPTH (BDEPTH),
			.AW    (BAW),
			.DW    (COST_BITS)
		) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (wdata),
			.re    (do_sample),
			.raddr (raddr),
			.rdata (bank_rd_s1[b])
		);
	end

	// pipeline registers
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 valid_s3;
	logic                 done_q;
	logic [FRAC_BITS-1:0] fx_s1;
	logic [FRAC_BITS-1:0] fy_s1;
	logic [FRAC_BITS-1:0] fy_s2;
	logic [1:0]           sel00_s1;
	logic [1:0]           sel01_s1;
	logic [1:0]           sel10_s1;
	logic [1:0]           sel11_s1;
	logic                 clamp_s1;
	logic                 clamp_s2;
	logic                 clamp_s3;
	logic [LW-1:0]        lo_s2;
	logic [LW-1:0]        hi_s2;
	logic [SW-1:0]        sum_s3;
	logic signed [HW-1:0] height_q;
	logic                 edge_q;

	// stage 1: corner select and horizontal blend
	logic [VW-1:0] v00;
	logic [VW-1:0] v01;
	logic [VW-1:0] v10;
	logic [VW-1:0] v11;
	logic [WW-1:0] wx0;
	logic [LW-1:0] lo_c;
	logic [LW-1:0] hi_c;

	always_comb begin
		if (map_present_q) begin
			v00 = VW'(bank_rd_s1[sel00_s1]);
			v01 = VW'(bank_rd_s1[sel01_s1]);
			v10 = VW'(bank_rd_s1[sel10_s1]);
			v11 = VW'(bank_rd_s1[sel11_s1]);
		end else begin
			// no map: every corner is 1.0, i.e. 2 in half-cost units
			v00 = VW'(2);
			v01 = VW'(2);
			v10 = VW'(2);
			v11 = VW'(2);
		end
		wx0  = ONE - WW'(fx_s1);
		lo_c = LW'(wx0) * LW'(v00) + LW'(fx_s1) * LW'(v01);
		hi_c = LW'(wx0) * LW'(v10) + LW'(fx_s1) * LW'(v11);
	end

	// stage 2: vertical blend
	logic [WW-1:0] wy0;
	logic [SW-1:0] sum_c;

	always_comb begin
		wy0   = ONE - WW'(fy_s2);
		sum_c = SW'(wy0) * SW'(lo_s2) + SW'(fy_s2) * SW'(hi_s2);
	end

	// stage 3: offset and saturation
	logic signed [EW-1:0] off_ext;
	logic signed [EW-1:0] off_scaled;
	logic signed [EW-1:0] h_full;
	logic signed [HW-1:0] h_sat;

	always_comb begin
		off_ext    = EW'(offset_q);
		// arithmetic right shift floors when the output unit is coarser
		off_scaled = (off_ext <<< OSH_L) >>> OSH_R;
		h_full     = signed'(EW'(sum_s3)) + off_scaled;
		if (h_full > H_MAX) begin
			h_sat = HW'(H_MAX);
		end else if (h_full < H_MIN) begin
			h_sat = HW'(H_MIN);
		end else begin
			h_sat = HW'(h_full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= do_sample;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (do_sample) begin
			fx_s1    <= fx;
			fy_s1    <= fy;
			sel00_s1 <= {r0[0], c0[0]};
			sel01_s1 <= {r0[0], c1[0]};
			sel10_s1 <= {r1[0], c0[0]};
			sel11_s1 <= {r1[0], c1[0]};
			clamp_s1 <= clamp;
		end
		lo_s2    <= lo_c;
		hi_s2    <= hi_c;
		fy_s2    <= fy_s1;
		clamp_s2 <= clamp_s1;
		sum_s3   <= sum_c;
		clamp_s3 <= clamp_s2;
		height_q <= h_sat;
		edge_q   <= clamp_s3;
	end

	assign done         = done_q;
	assign height       = height_q;
	assign edge_clamped = edge_q;

endmodule

// ----- src/gbhs_checker.sv -----
// ----------------------------------------------------------------------------
// gbhs_checker
// Port-level checks of the height sampler: fixed result latency and
// permanent readiness of both channels.
// ----------------------------------------------------------------------------
module gbhs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic done,
	input logic cfg_ready
);

	logic sample_xfer;

	assign sample_xfer = arst_n && start && !busy &&
		(gbhs_pkg::kind_t'(kind) == gbhs_pkg::KIND_SAMPLE);

	// every sample transfer gives a result
	a_sample_done: assert property (@(posedge clk) disable iff (!arst_n)
		sample_xfer |-> ##4 done)
		else $error("sample transfer without result");

	// no result appears without an earlier sample transfer
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(sample_xfer, 4))
		else $error("result without matching sample transfer");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind grid_bilinear_height_sampler gbhs_checker u_gbhs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.kind      (kind),
	.done      (done),
	.cfg_ready (cfg_ready)
);
